/* hdl/laplacian_sharpen_rgb_defines.svh */
// Assertion macros for the Laplacian sharpening block.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef LAPLACIAN_SHARPEN_RGB_DEFINES_SVH
`define LAPLACIAN_SHARPEN_RGB_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSR_ASSERT_IMPLIES(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define LSR_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`define LSR_ASSERT_NEVER(lbl, a, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) else $error(msg);
`else
`define LSR_ASSERT_IMPLIES(lbl, a, b, msg)
`define LSR_ASSERT_NEXT(lbl, a, b, msg)
`define LSR_ASSERT_NEVER(lbl, a, msg)
`endif
`endif

/* hdl/lsr_pkg.sv */
// Shared types and constants for the Laplacian sharpening block.
// No dependencies.
`default_nettype none
package lsr_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // one line store entry: pixel two rows up and one row up, same column
  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_t;

  // four-neighbour cross around the centre pixel
  typedef struct packed {
    rgb_t up;
    rgb_t down;
    rgb_t left;
    rgb_t right;
    rgb_t centre;
  } cross_t;

  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int REG_IDX_W  = 2;
  localparam int GAIN_W     = 8;
  localparam int ROW_W      = 13;  // input row counts up to the full height
  localparam int OROW_W     = 12;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN         = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_H_W-1:0] MAX_HEIGHT    = 13'd4096;
  localparam logic [CFG_H_W-1:0] RST_HEIGHT    = 13'd480;
  localparam int                 RST_WIDTH     = 640;
  localparam logic [GAIN_W-1:0]  RST_GAIN      = 8'sd1;

  localparam logic [7:0] PIX_MAX = 8'd255;
  localparam logic [7:0] PIX_MIN = 8'd0;

endpackage
`default_nettype wire

/* hdl/lsr_in_if.sv */
// Input pixel channel: valid/ready plus opcode and RGB.
// No dependencies.
`default_nettype none
interface lsr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, opcode, red, green, blue, input ready);
  modport sink   (input valid, opcode, red, green, blue, output ready);
endinterface
`default_nettype wire

/* hdl/lsr_out_if.sv */
// Result pixel channel: valid/ready plus RGB and frame_last.
// No dependencies.
`default_nettype none
interface lsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface
`default_nettype wire

/* hdl/lsr_cfg_if.sv */
// Configuration write channel: valid/ready, register index and data.
// Depends on lsr_pkg for widths.
`default_nettype none
interface lsr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsr_pkg::REG_IDX_W-1:0]   index;
  logic [lsr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/laplacian_sharpen_rgb.sv */
// Path: the input word that releases a result word passes the line store read and stage 1 register,
// then the window registers (window update), then the sharpen into the output register; stalls can hold it.
// Throughput: one word per clock; the line store's one read and one write port a
// cycle set that rate. Ready drops only when the output register is held.
// Reset: counters to zero, geometry 640 x 480, gain 1; line store is not cleared.
`default_nettype none
`include "laplacian_sharpen_rgb_defines.svh"
module laplacian_sharpen_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lsr_in_if.sink      in_ch,
  lsr_out_if.source   out_ch,
  lsr_cfg_if.sink     cfg_ch
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW   = (EW_W > lsr_pkg::CFG_W_W) ? EW_W : lsr_pkg::CFG_W_W;
  localparam int RST_W  = (lsr_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : lsr_pkg::RST_WIDTH;
  localparam int ROW_W  = lsr_pkg::ROW_W;
  localparam int OROW_W = lsr_pkg::OROW_W;
  localparam int LINE_W = $bits(lsr_pkg::line_t);

  // configuration, held as effective values
  logic [EW_W-1:0]           width_r;
  logic [lsr_pkg::CFG_H_W-1:0] height_r;
  logic signed [7:0]         gain_r;

  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  // stage 1: item waiting on line store read data
  logic               s1_v_r, s1_res_r, s1_border_r, s1_last_r, s1_byp_r;
  logic [COL_W-1:0]   s1_col_r;
  lsr_pkg::rgb_t      s1_pix_r;
  lsr_pkg::line_t     s1_byp_d_r;
  // stage 2: window holds the neighbourhood of the item
  logic               s2_v_r, s2_res_r, s2_border_r, s2_last_r;
  lsr_pkg::rgb_t      up_c_r, up_r_r, mid_l_r, mid_c_r, mid_r_r, dn_c_r, dn_r_r;
  // output register
  logic               out_valid_r, out_last_r;
  lsr_pkg::rgb_t      out_px_r;

  logic               cfg_wr, geom_wr, in_acc, take, row_done, has_res;
  logic               col_last, ocol_last, orow_last, border, frame_end, byp;
  logic               s1_ready, s1_adv, s2_ready, out_free;
  logic [lsr_pkg::CFG_W_W-1:0] cfg_w_raw;
  logic [lsr_pkg::CFG_H_W-1:0] cfg_h_raw, h_eff;
  logic [EW_W-1:0]    w_eff;
  lsr_pkg::rgb_t      pix_in, s1_top, s1_mid;
  lsr_pkg::line_t     mem_q, s1_line, wr_line;
  lsr_pkg::cross_t    win;
  lsr_pkg::rgb_t      sharp_px;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr    = cfg_ch.valid && cfg_ch.ready;
  assign geom_wr   = cfg_wr && ((cfg_ch.index == lsr_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_ch.index == lsr_pkg::REG_IMAGE_HEIGHT));
  assign cfg_w_raw = cfg_ch.data[lsr_pkg::CFG_W_W-1:0];
  assign cfg_h_raw = cfg_ch.data[lsr_pkg::CFG_H_W-1:0];

  always_comb begin
    priority if (cfg_w_raw == '0) begin
      w_eff = EW_W'(1);
    end else if (CMPW'(cfg_w_raw) > CMPW'(MAX_WIDTH)) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(cfg_w_raw);
    end
    priority if (cfg_h_raw == '0) begin
      h_eff = lsr_pkg::CFG_H_W'(1);
    end else if (cfg_h_raw > lsr_pkg::MAX_HEIGHT) begin
      h_eff = lsr_pkg::MAX_HEIGHT;
    end else begin
      h_eff = cfg_h_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= EW_W'(RST_W);
      height_r <= lsr_pkg::RST_HEIGHT;
      gain_r   <= lsr_pkg::RST_GAIN;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        lsr_pkg::REG_IMAGE_WIDTH:  width_r  <= w_eff;
        lsr_pkg::REG_IMAGE_HEIGHT: height_r <= h_eff;
        lsr_pkg::REG_GAIN:         gain_r   <= cfg_ch.data[lsr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input decode and frame counters ----------------
  assign s1_ready    = !s1_v_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign row_done    = in_row_r >= height_r;
  // pixels after the frame and flushes during it are dropped
  assign take        = in_acc && ((in_ch.opcode == lsr_pkg::OP_PIXEL) ? !row_done : row_done);
  assign pix_in      = (in_ch.opcode == lsr_pkg::OP_PIXEL) ?
                       {in_ch.red, in_ch.green, in_ch.blue} : '0;

  assign has_res   = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign col_last  = (EW_W'(in_col_r) + EW_W'(1)) == width_r;
  assign ocol_last = (EW_W'(out_col_r) + EW_W'(1)) == width_r;
  assign orow_last = (ROW_W'(out_row_r) + ROW_W'(1)) == height_r;
  assign border    = (out_row_r == '0) || orow_last || (out_col_r == '0) || ocol_last;
  assign frame_end = orow_last && ocol_last;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (geom_wr || (take && has_res && frame_end)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (has_res) begin
        if (ocol_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------- line store ----------------
  // forward the entry being written when the next word reads the same column
  assign s1_adv  = s1_v_r && s2_ready;
  assign byp     = s1_adv && (s1_col_r == in_col_r);
  assign s1_line = s1_byp_r ? s1_byp_d_r : mem_q;
  assign s1_top  = s1_line.upper;
  assign s1_mid  = s1_line.middle;
  assign wr_line = '{upper: s1_mid, middle: s1_pix_r};

  lsr_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (LINE_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (mem_q),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (wr_line)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= take;
    end
    if (s1_ready && take) begin
      s1_pix_r    <= pix_in;
      s1_col_r    <= in_col_r;
      s1_res_r    <= has_res;
      s1_border_r <= border;
      s1_last_r   <= has_res && frame_end;
      s1_byp_r    <= byp;
      s1_byp_d_r  <= wr_line;
    end
  end

  // ---------------- window ----------------
  assign out_free = !out_valid_r || out_ch.ready;
  assign s2_ready = !s2_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      up_c_r  <= '0;
      up_r_r  <= '0;
      mid_l_r <= '0;
      mid_c_r <= '0;
      mid_r_r <= '0;
      dn_c_r  <= '0;
      dn_r_r  <= '0;
    end else begin
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s1_adv) begin
        up_c_r  <= up_r_r;
        up_r_r  <= s1_top;
        mid_l_r <= mid_c_r;
        mid_c_r <= mid_r_r;
        mid_r_r <= s1_mid;
        dn_c_r  <= dn_r_r;
        dn_r_r  <= s1_pix_r;
      end
    end
    if (s1_adv) begin
      s2_res_r    <= s1_res_r;
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
    end
  end

  // ---------------- sharpen and output register ----------------
  assign win = '{up: up_c_r, down: dn_c_r, left: mid_l_r, right: mid_r_r, centre: mid_c_r};

  lsr_sharpen u_sharpen (
    .win    (win),
    .gain   (gain_r),
    .border (s2_border_r),
    .pix    (sharp_px)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_v_r && s2_res_r;
    end
    if (out_free && s2_v_r) begin
      out_px_r   <= sharp_px;
      out_last_r <= s2_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_red    = out_px_r.r;
  assign out_ch.out_green  = out_px_r.g;
  assign out_ch.out_blue   = out_px_r.b;
  assign out_ch.frame_last = out_last_r;

  // ---------------- assertions ----------------
  `LSR_ASSERT_NEXT(a_frame_restart, take && has_res && frame_end, (in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0), "counters not cleared after frame end")
  `LSR_ASSERT_NEVER(a_in_col_range, EW_W'(in_col_r) >= width_r, "input column beyond width")
  `LSR_ASSERT_NEVER(a_out_row_range, ROW_W'(out_row_r) >= height_r, "output row beyond height")
  `LSR_ASSERT_IMPLIES(a_last_has_res, s1_v_r && s1_last_r, s1_res_r, "frame end flagged on a word with no result")

endmodule
`default_nettype wire

/* hdl/lsr_line_mem.sv */
// Line store RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none
module lsr_line_mem #(
  parameter  int DEPTH = 2048,
  parameter  int DW    = 48,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* hdl/lsr_sharpen.sv */
// Per-colour Laplacian sharpening with clamp, or plain pass-through on the border.
// Depends on lsr_pkg for the pixel and window types.
`default_nettype none
module lsr_sharpen (
  input  wire lsr_pkg::cross_t    win,
  input  wire logic signed [7:0]  gain,
  input  wire logic               border,
  output lsr_pkg::rgb_t           pix
);

  // kernel 0 1 0 / 1 -4 1 / 0 1 0, result = centre - gain * laplacian
  function automatic logic [7:0] sharp_ch(input logic [7:0] u, input logic [7:0] d,
                                          input logic [7:0] l, input logic [7:0] r,
                                          input logic [7:0] c,
                                          input logic signed [7:0] g);
    logic signed [10:0] lap;
    logic signed [18:0] prod;
    logic signed [19:0] res;
    lap  = $signed({3'b000, u}) + $signed({3'b000, d}) + $signed({3'b000, l})
         + $signed({3'b000, r}) - $signed({1'b0, c, 2'b00});
    prod = 19'(g) * 19'(lap);
    res  = $signed({12'd0, c}) - 20'(prod);
    if (res < 20'sd0) begin
      sharp_ch = lsr_pkg::PIX_MIN;
    end else if (res > 20'sd255) begin
      sharp_ch = lsr_pkg::PIX_MAX;
    end else begin
      sharp_ch = res[7:0];
    end
  endfunction

  always_comb begin
    if (border) begin
      pix = win.centre;
    end else begin
      pix.r = sharp_ch(win.up.r, win.down.r, win.left.r, win.right.r, win.centre.r, gain);
      pix.g = sharp_ch(win.up.g, win.down.g, win.left.g, win.right.g, win.centre.g, gain);
      pix.b = sharp_ch(win.up.b, win.down.b, win.left.b, win.right.b, win.centre.b, gain);
    end
  end

endmodule
`default_nettype wire
